[hw/rtl/rgbycc_pkg.sv]
package rgbycc_pkg;

	localparam int PixelW = 16;
	localparam int CompW  = 8;
	localparam int ProdW  = 17;

	localparam logic [PixelW-1:0] AvgMask  = 16'hF7DF;
	localparam logic [CompW-1:0]  RbMask   = 8'hF8;
	localparam logic [CompW-1:0]  GMask    = 8'hFC;
	localparam logic [CompW-1:0]  LumaOfs  = 8'd16;
	localparam logic [CompW-1:0]  ChromaOfs = 8'd128;

	localparam logic [ProdW-1:0] KyR  = 17'd65;
	localparam logic [ProdW-1:0] KyG  = 17'd129;
	localparam logic [ProdW-1:0] KyB  = 17'd25;
	localparam logic signed [ProdW-1:0] KcbR = 17'sd37;
	localparam logic signed [ProdW-1:0] KcbG = 17'sd74;
	localparam logic signed [ProdW-1:0] KcB  = 17'sd112;
	localparam logic signed [ProdW-1:0] KcrG = 17'sd94;
	localparam logic signed [ProdW-1:0] KcrB = 17'sd18;

	function automatic logic [CompW-1:0] red8(input logic [PixelW-1:0] p);
		return p[15:8] & RbMask;
	endfunction

	function automatic logic [CompW-1:0] green8(input logic [PixelW-1:0] p);
		return p[10:3] & GMask;
	endfunction

	function automatic logic [CompW-1:0] blue8(input logic [PixelW-1:0] p);
		return {p[4:0], 3'b000} & RbMask;
	endfunction

	// luma = 16 + ((65R + 129G + 25B) >> 8), always below 256
	function automatic logic [CompW-1:0] luma_of(input logic [PixelW-1:0] p);
		logic [ProdW-1:0] sum;
		sum = KyR * {9'd0, red8(p)} + KyG * {9'd0, green8(p)} + KyB * {9'd0, blue8(p)};
		return sum[15:8] + LumaOfs;
	endfunction

	// 565 average: identity on equal pixels, else masked add and halve
	function automatic logic [PixelW-1:0] avg565(input logic [PixelW-1:0] a,
		input logic [PixelW-1:0] b);
		logic [PixelW:0] sum;
		sum = {1'b0, a & AvgMask} + {1'b0, b & AvgMask};
		return (a == b) ? a : sum[PixelW:1];
	endfunction

	function automatic logic [CompW-1:0] cb_of(input logic [PixelW-1:0] p);
		logic signed [ProdW-1:0] sum;
		logic signed [ProdW-1:0] q;
		sum = KcbR * $signed({9'd0, red8(p)}) + KcbG * $signed({9'd0, green8(p)})
			- KcB * $signed({9'd0, blue8(p)});
		q = sum >>> 8;
		return ChromaOfs - q[CompW-1:0];
	endfunction

	function automatic logic [CompW-1:0] cr_of(input logic [PixelW-1:0] p);
		logic signed [ProdW-1:0] sum;
		logic signed [ProdW-1:0] q;
		sum = KcB * $signed({9'd0, red8(p)}) - KcrG * $signed({9'd0, green8(p)})
			- KcrB * $signed({9'd0, blue8(p)});
		q = sum >>> 8;
		return ChromaOfs + q[CompW-1:0];
	endfunction

endpackage

[hw/rtl/rgb565_to_ycbcr422_packer_top.sv]
// A pair's CbYCrY item passes the input register, then the output register.
// One pixel per cycle unless the output stalls; one output item per pixel pair.
// The single pass holds an input register, the pair state and an output register.
// Reset (arst_n low, asynchronous) clears the valid flags, the pair phase,
// the held pixel and the held luma to zero.
module rgb565_to_ycbcr422_packer_top import rgbycc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PixelW-1:0] pixel,
	input  logic              line_start,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CompW-1:0]  cb,
	output logic [CompW-1:0]  luma_first,
	output logic [CompW-1:0]  cr,
	output logic [CompW-1:0]  luma_second
);

	logic              valid_s1;
	logic [PixelW-1:0] pixel_s1;
	logic              line_start_s1;

	logic              odd_phase_q;
	logic [PixelW-1:0] held_pixel_q;
	logic [CompW-1:0]  held_luma_q;

	logic              first_s1;
	logic              emit_s1;
	logic              move_s1;
	logic [CompW-1:0]  luma_s1;
	logic [PixelW-1:0] avg_s1;

	// pair logic on the registered item
	assign first_s1 = line_start_s1 | ~odd_phase_q;
	assign emit_s1  = valid_s1 & ~first_s1;
	assign move_s1  = ~emit_s1 | ~out_valid | ~out_stall;
	assign in_stall = valid_s1 & ~move_s1;
	assign luma_s1  = luma_of(pixel_s1);
	assign avg_s1   = avg565(held_pixel_q, pixel_s1);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (move_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && in_valid) begin
			pixel_s1      <= pixel;
			line_start_s1 <= line_start;
		end
	end

	// pair state: hold the first pixel, clear phase on the second
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_phase_q  <= 1'b0;
			held_pixel_q <= '0;
			held_luma_q  <= '0;
		end else if (valid_s1 && move_s1) begin
			if (first_s1) begin
				odd_phase_q  <= 1'b1;
				held_pixel_q <= pixel_s1;
				held_luma_q  <= luma_s1;
			end else begin
				odd_phase_q <= 1'b0;
			end
		end
	end

	// output register: load a new item or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_s1 && move_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1 && move_s1) begin
			cb          <= cb_of(avg_s1);
			luma_first  <= held_luma_q;
			cr          <= cr_of(avg_s1);
			luma_second <= luma_s1;
		end
	end

endmodule

[tb/tb_rgb565_to_ycbcr422_packer_top.sv]
module tb_rgb565_to_ycbcr422_packer_top;
	import rgbycc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PixelTarget = 850;
	localparam int HoldCycles  = 160;
	localparam int DrainLimit  = 20000;
	localparam int TailCycles  = 8;

	typedef struct packed {
		logic [CompW-1:0] cb;
		logic [CompW-1:0] y0;
		logic [CompW-1:0] cr;
		logic [CompW-1:0] y1;
	} cbycry_t;

	// Pair-phase predictor and the CbYCrY words it still expects
	class ycc_pair_model;
		bit                odd_phase;
		logic [PixelW-1:0] held_pixel;
		logic [CompW-1:0]  held_luma;
		cbycry_t           words[$];
		int                mismatches;

		function new();
			odd_phase  = 1'b0;
			held_pixel = '0;
			held_luma  = '0;
			mismatches = 0;
		endfunction

		static function logic [CompW-1:0] luma(input logic [PixelW-1:0] p);
			int r;
			int g;
			int b;
			r = {p[15:11], 3'b000};
			g = {p[10:5], 2'b00};
			b = {p[4:0], 3'b000};
			return 8'(16 + ((65 * r + 129 * g + 25 * b) >> 8));
		endfunction

		// Equal pixels pass through; otherwise masked add and halve
		static function logic [PixelW-1:0] pair_mean(input logic [PixelW-1:0] a,
			input logic [PixelW-1:0] b);
			logic [PixelW:0] s;
			s = {1'b0, a & AvgMask} + {1'b0, b & AvgMask};
			return (a == b) ? a : s[PixelW:1];
		endfunction

		// Build the output word on the second pixel of a pair
		function void take_pixel(input logic [PixelW-1:0] p, input logic ls);
			logic [PixelW-1:0] m;
			int r;
			int g;
			int b;
			int s_cb;
			int s_cr;
			cbycry_t w;
			if (ls || !odd_phase) begin
				held_pixel = p;
				held_luma  = luma(p);
				odd_phase  = 1'b1;
				return;
			end
			m = pair_mean(held_pixel, p);
			r = {m[15:11], 3'b000};
			g = {m[10:5], 2'b00};
			b = {m[4:0], 3'b000};
			s_cb = 37 * r + 74 * g - 112 * b;
			s_cr = 112 * r - 94 * g - 18 * b;
			w.cb = 8'(128 - (s_cb >>> 8));
			w.cr = 8'(128 + (s_cr >>> 8));
			w.y0 = held_luma;
			w.y1 = luma(p);
			words.push_back(w);
			odd_phase = 1'b0;
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task cmp_field(input string fname, input logic [CompW-1:0] got,
			input logic [CompW-1:0] want);
			if (got !== want) begin
				report_mismatch($sformatf("%s got %02h expected %02h", fname, got, want));
			end
		endtask

		// Compare one output word with the oldest expected one
		task check_word(input logic [CompW-1:0] cb, input logic [CompW-1:0] y0,
			input logic [CompW-1:0] cr, input logic [CompW-1:0] y1);
			cbycry_t w;
			if (words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h %02h %02h %02h",
					cb, y0, cr, y1));
				return;
			end
			w = words.pop_front();
			cmp_field("cb", cb, w.cb);
			cmp_field("luma_first", y0, w.y0);
			cmp_field("cr", cr, w.cr);
			cmp_field("luma_second", y1, w.y1);
		endtask

		task flush_leftover();
			while (words.size() != 0) begin
				void'(words.pop_front());
				report_mismatch("expected word never arrived");
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [PixelW-1:0] pixel;
	logic              line_start;
	logic              out_valid;
	logic              out_stall;
	logic [CompW-1:0]  cb;
	logic [CompW-1:0]  luma_first;
	logic [CompW-1:0]  cr;
	logic [CompW-1:0]  luma_second;

	ycc_pair_model pairs = new();

	bit                tx_idle;
	int                rx_mode;
	bit                hold_req;
	int                pixels_sent;
	logic [PixelW-1:0] last_pixel;

	rgb565_to_ycbcr422_packer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.line_start  (line_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cb          (cb),
		.luma_first  (luma_first),
		.cr          (cr),
		.luma_second (luma_second)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// Sample both handshakes at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				pairs.check_word(cb, luma_first, cr, luma_second);
			end
			if (in_valid && !in_stall) begin
				pairs.take_pixel(pixel, line_start);
			end
		end
	end

	// Receiver: no stalls, random stalls, or one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (rx_mode == 0) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = gap_len() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one pixel and hold it until taken, then maybe idle
	task send_pixel(input logic [PixelW-1:0] p, input logic ls);
		pixel      <= p;
		line_start <= ls;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
		last_pixel = p;
		if (tx_idle && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Random pixel, biased toward equal pairs, extremes and near neighbors
	function automatic logic [PixelW-1:0] pick_pixel();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				return last_pixel;
			end
			1: begin
				return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			2: begin
				return last_pixel ^ (16'h1 << $urandom_range(0, 15));
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// One line: mostly even length with a line start, sometimes broken
	task send_line();
		int len;
		logic ls;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : 2 * $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			if (i == 0) begin
				ls = ($urandom_range(0, 19) != 0);
			end else begin
				ls = ($urandom_range(0, 32) == 0);
			end
			send_pixel(pick_pixel(), ls);
		end
	endtask

	initial begin
		int spin;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		pixel      <= '0;
		line_start <= 1'b0;
		tx_idle     = 1'b0;
		rx_mode     = 0;
		hold_req    = 1'b0;
		pixels_sent = 0;
		last_pixel  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: start without line flag, extremes, equal pairs, dropped first pixel
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hF800, 1'b1);
		send_pixel(16'h001F, 1'b0);
		send_pixel(16'h07E0, 1'b0);
		send_pixel(16'hF81F, 1'b0);
		send_pixel(16'h1234, 1'b1);
		send_pixel(16'hABCD, 1'b1);
		send_pixel(16'h0820, 1'b0);
		send_pixel(16'h0821, 1'b0);
		send_pixel(16'h0820, 1'b0);
		send_pixel(16'h5555, 1'b1);
		send_pixel(16'hAAAA, 1'b0);
		send_pixel(16'h001F, 1'b1);
		send_pixel(16'hF800, 1'b0);

		// Random lines with idling on both sides
		tx_idle = 1'b1;
		rx_mode = 1;
		while (pixels_sent < 320) send_line();

		// Long receiver hold-off while pixels keep coming back to back
		tx_idle  = 1'b0;
		hold_req = 1'b1;
		while (pixels_sent < 420) send_line();

		// Full rate, no idling at all
		rx_mode = 0;
		while (pixels_sent < 620) send_line();

		tx_idle = 1'b1;
		rx_mode = 1;
		while (pixels_sent < PixelTarget) send_line();
		in_valid <= 1'b0;

		// Drain outstanding words, then watch for strays
		spin = 0;
		while (pairs.words.size() != 0 && spin < DrainLimit) begin
			@(posedge clk);
			spin++;
		end
		repeat (TailCycles) @(posedge clk);
		pairs.flush_leftover();
		if (pairs.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
